[hw/rtl/rsd_pkg.sv]
package rsd_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned RUN_LEN_W   = 7;
    localparam int unsigned SRC_COL_W   = 9;
    localparam int unsigned CLIP_X_W    = 11;
    localparam int unsigned CLIP_W_W    = 10;
    localparam int unsigned ZOOM_W      = 2;
    localparam int unsigned OUT_COL_W   = 10;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 11;

    // header byte layout
    localparam logic [BYTE_W-1:0] END_BIT  = 8'h80;
    localparam logic [BYTE_W-1:0] LEN_MASK = 8'h7F;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_START_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_WIDTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ZOOM_SHIFT   = 2'd2;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_START  = 2'd1,
        PH_PIXEL  = 2'd2
    } phase_t;

    typedef struct packed {
        phase_t                 phase;
        logic [RUN_LEN_W-1:0]   run_left;
        logic [SRC_COL_W-1:0]   pixel_column;
        logic                   last_run;
    } parse_state_t;

    typedef struct packed {
        logic signed [CLIP_X_W-1:0] clip_start_x;
        logic [CLIP_W_W-1:0]        clip_width;
        logic [ZOOM_W-1:0]          zoom_shift;
    } cfg_t;

    typedef struct packed {
        logic                   write_enable;
        logic [OUT_COL_W-1:0]   out_column;
        logic [BYTE_W-1:0]      pixel_index;
        logic                   row_end;
    } result_t;

endpackage

[hw/rtl/rsd_step.sv]
// One byte of run parsing: next parse state and the result word.
module rsd_step (
    input  rsd_pkg::parse_state_t       st,
    input  rsd_pkg::cfg_t               cfg,
    input  logic [rsd_pkg::BYTE_W-1:0]  rle_byte,
    output rsd_pkg::parse_state_t       st_next,
    output rsd_pkg::result_t            res
);

    logic signed [rsd_pkg::CLIP_X_W:0] col;
    logic [2:0]                        step_mask;
    logic                              visible;
    logic [rsd_pkg::RUN_LEN_W-1:0]     run_dec;

    always_comb begin
        // column relative to clip start, 12 bits signed
        col = $signed({3'b000, st.pixel_column})
            - $signed({cfg.clip_start_x[rsd_pkg::CLIP_X_W-1], cfg.clip_start_x});
        step_mask = ~(3'b111 << cfg.zoom_shift);
        visible = !col[rsd_pkg::CLIP_X_W]
                && (col[rsd_pkg::CLIP_X_W-1:0] < {1'b0, cfg.clip_width})
                && ((col[2:0] & step_mask) == 3'b000);
        run_dec = st.run_left - 7'd1;

        st_next = st;
        res     = '0;

        unique case (st.phase)
            rsd_pkg::PH_START: begin
                st_next.pixel_column = {1'b0, rle_byte};
                if (st.run_left == '0) begin
                    res.row_end   = st.last_run;
                    st_next.phase = rsd_pkg::PH_HEADER;
                end else begin
                    st_next.phase = rsd_pkg::PH_PIXEL;
                end
            end
            rsd_pkg::PH_PIXEL: begin
                if (visible) begin
                    res.write_enable = 1'b1;
                    res.out_column   = col[rsd_pkg::OUT_COL_W-1:0] >> cfg.zoom_shift;
                    res.pixel_index  = rle_byte;
                end
                st_next.pixel_column = st.pixel_column + 9'd1;
                st_next.run_left     = run_dec;
                if (run_dec == '0) begin
                    res.row_end   = st.last_run;
                    st_next.phase = rsd_pkg::PH_HEADER;
                end
            end
            default: begin
                // header byte; the unused phase code lands here too
                st_next.run_left = rle_byte[rsd_pkg::RUN_LEN_W-1:0]
                                 & rsd_pkg::LEN_MASK[rsd_pkg::RUN_LEN_W-1:0];
                st_next.last_run = (rle_byte & rsd_pkg::END_BIT) != '0;
                st_next.phase    = rsd_pkg::PH_START;
            end
        endcase
    end

endmodule

[hw/rtl/rle_sprite_row_decoder.sv]
// Run-length sprite row decoder.
// An accepted byte's result word is registered into the main register, or into skid while main is stalled.
// Throughput: 1 byte per cycle while s_ready is high; parse step is combinational compare/mask/shift logic.
// A 2-deep output (main + skid register) accepts one byte while main is stalled; s_ready then drops.
// Reset (aresetn low, synchronous): config regs to 0, parser expects a run header,
// no result words held.
module rle_sprite_row_decoder (
    input  logic                                aclk,
    input  logic                                aresetn,

    // configuration write port
    input  logic                                cfg_wr_en,
    input  logic [rsd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rsd_pkg::CFG_DATA_W-1:0]      cfg_wdata,

    // run data in
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [rsd_pkg::BYTE_W-1:0]          s_rle_byte,

    // pixel write words out
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_write_enable,
    output logic [rsd_pkg::OUT_COL_W-1:0]       m_out_column,
    output logic [rsd_pkg::BYTE_W-1:0]          m_pixel_index,
    output logic                                m_row_end
);

    rsd_pkg::cfg_t          cfg_reg;
    rsd_pkg::parse_state_t  st_reg;
    rsd_pkg::parse_state_t  st_next;
    rsd_pkg::result_t       step_res;

    rsd_pkg::result_t       main_reg;
    rsd_pkg::result_t       skid_reg;
    logic                   main_valid_reg;
    logic                   main_valid_next;
    logic                   skid_valid_reg;
    logic                   skid_valid_next;
    logic                   load_main;
    logic                   load_skid;
    logic                   main_from_skid;
    logic                   s_accept;

    // ------------------------------------------------------------------
    // Configuration: low register bits are kept, unknown index ignored.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                rsd_pkg::REG_CLIP_START_X: cfg_reg.clip_start_x <= $signed(cfg_wdata);
                rsd_pkg::REG_CLIP_WIDTH:   cfg_reg.clip_width <=
                                               cfg_wdata[rsd_pkg::CLIP_W_W-1:0];
                rsd_pkg::REG_ZOOM_SHIFT:   cfg_reg.zoom_shift <=
                                               cfg_wdata[rsd_pkg::ZOOM_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Parser: state advances on every accepted byte.
    // ------------------------------------------------------------------
    rsd_step u_step (
        .st       (st_reg),
        .cfg      (cfg_reg),
        .rle_byte (s_rle_byte),
        .st_next  (st_next),
        .res      (step_res)
    );

    // ready only drops when the skid slot is occupied
    assign s_ready  = !skid_valid_reg;
    assign s_accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= '{phase: rsd_pkg::PH_HEADER, run_left: '0,
                        pixel_column: '0, last_run: 1'b0};
        end else if (s_accept) begin
            st_reg <= st_next;
        end
    end

    // ------------------------------------------------------------------
    // Output main + skid registers.
    // Main reg drains when empty or taken; skid refills it first.
    // A byte arriving while main is stalled parks in skid.
    // ------------------------------------------------------------------
    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        load_main       = 1'b0;
        load_skid       = 1'b0;
        main_from_skid  = 1'b0;
        if (!main_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                load_main       = 1'b1;
                main_from_skid  = 1'b1;
                main_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end else if (s_accept) begin
                load_main       = 1'b1;
                main_valid_next = 1'b1;
            end else begin
                main_valid_next = 1'b0;
            end
        end else if (s_accept) begin
            load_skid       = 1'b1;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (load_main) begin
            main_reg <= main_from_skid ? skid_reg : step_res;
        end
        if (load_skid) begin
            skid_reg <= step_res;
        end
    end

    assign m_valid        = main_valid_reg;
    assign m_write_enable = main_reg.write_enable;
    assign m_out_column   = main_reg.out_column;
    assign m_pixel_index  = main_reg.pixel_index;
    assign m_row_end      = main_reg.row_end;

`ifndef SYNTHESIS
    // skid holds a word only behind a held main word
    a_skid_behind_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid word without main word");

    // full output with a stall must back-pressure the input
    a_full_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg && !m_ready |=> !s_ready)
        else $error("input ready while output full");

    // header byte always moves parser to start-column phase
    a_header_to_start: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && (st_reg.phase == rsd_pkg::PH_HEADER) |=>
            st_reg.phase == rsd_pkg::PH_START)
        else $error("header byte did not advance to start phase");

    // no pixel write means zeroed column and index
    a_idle_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_write_enable |-> (m_out_column == '0) && (m_pixel_index == '0))
        else $error("nonzero pixel fields without write");
`endif

endmodule
